/* hdl/image_rotate_90_macros.svh */
// assertion helpers shared by the checking code of the rotation engine
`ifndef IMAGE_ROTATE_90_MACROS_SVH
`define IMAGE_ROTATE_90_MACROS_SVH

// same-cycle implication, quiet during reset
`define IROT_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define IROT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/irot90_pkg.sv */
package irot90_pkg;

    localparam int COLOR_W    = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_ROTATE_DIR   = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic is_read;
        logic last;
    } item_tag_t;

endpackage

/* hdl/irot90_if.sv */
interface irot90_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, command, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface irot90_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       pixel_valid;
    logic       frame_last;

    modport source (output valid, red_out, green_out, blue_out, pixel_valid, frame_last,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, pixel_valid, frame_last,
                    output ready);
endinterface

/* hdl/irot90_ram.sv */
module irot90_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/irot90_queue.sv */
module irot90_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    assign full      = (fill_reg == NW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = NW'(fill_reg + NW'(1));
        end
        else if (pop && !push)
        begin
            fill_next = NW'(fill_reg - NW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

/* hdl/irot90_front.sv */
module irot90_front #(
    parameter int MAX_SIDE   = 256,
    parameter int MAX_PIXELS = 65536
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    irot90_in_if.sink                              pix_in,
    input  logic [$clog2(MAX_SIDE+1)-1:0]          side_w,
    input  logic [$clog2(MAX_SIDE+1)-1:0]          side_h,
    input  logic                                   dir,
    input  logic [$clog2(MAX_PIXELS+1)-1:0]        frame_count,
    input  logic                                   q_full,
    output logic                                   push,
    output irot90_pkg::item_tag_t                  tag,
    output irot90_pkg::pixel_t                     pix,
    output logic [((($clog2(MAX_SIDE)+$clog2(MAX_SIDE+1)) > $clog2(MAX_PIXELS)) ?
                   ($clog2(MAX_SIDE)+$clog2(MAX_SIDE+1)) : $clog2(MAX_PIXELS))-1:0] base,
    output logic [$clog2(MAX_SIDE)-1:0]            offset
);
    import irot90_pkg::*;

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int PROD_W = CW + SIDE_W;
    localparam int BASE_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    logic [ADDR_W-1:0] load_idx_reg, load_idx_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;

    logic [ADDR_W-1:0] li_c;
    logic [CNT_W-1:0]  li_inc;
    logic              load_last;
    logic [CW-1:0]     i_c, j_c;
    logic [SIDE_W-1:0] w_m1, h_m1;
    logic              row_end, col_end;
    logic [CW-1:0]     mul_a, off_c;
    logic [PROD_W-1:0] prod;
    logic              accept;

    assign pix_in.ready = !q_full;
    assign accept       = pix_in.valid && !q_full;
    assign push         = accept;

    always_comb
    begin
        // counters left outside a resized frame restart at zero
        li_c      = (CNT_W'(load_idx_reg) >= frame_count) ? '0 : load_idx_reg;
        li_inc    = CNT_W'(li_c) + CNT_W'(1);
        load_last = (li_inc >= frame_count);

        i_c  = (SIDE_W'(row_reg) >= side_w) ? '0 : row_reg;
        j_c  = (SIDE_W'(col_reg) >= side_h) ? '0 : col_reg;
        w_m1 = SIDE_W'(side_w - SIDE_W'(1));
        h_m1 = SIDE_W'(side_h - SIDE_W'(1));
        row_end = (SIDE_W'(i_c) == w_m1);
        col_end = (SIDE_W'(j_c) == h_m1);

        if (dir == DIR_CW)
        begin
            mul_a = CW'(h_m1 - SIDE_W'(j_c));
            off_c = i_c;
        end
        else
        begin
            mul_a = j_c;
            off_c = CW'(w_m1 - SIDE_W'(i_c));
        end
        prod = PROD_W'(mul_a) * PROD_W'(side_w);

        pix.red   = pix_in.red_in;
        pix.green = pix_in.green_in;
        pix.blue  = pix_in.blue_in;

        if (pix_in.command == CMD_READ)
        begin
            tag.is_read = 1'b1;
            tag.last    = row_end && col_end;
            base        = BASE_W'(prod);
            offset      = off_c;
        end
        else
        begin
            tag.is_read = 1'b0;
            tag.last    = load_last;
            base        = BASE_W'(li_c);
            offset      = '0;
        end

        load_idx_next = load_idx_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        if (accept)
        begin
            if (pix_in.command == CMD_READ)
            begin
                if (col_end)
                begin
                    col_next = '0;
                    row_next = row_end ? '0 : CW'(i_c + CW'(1));
                end
                else
                begin
                    col_next = CW'(j_c + CW'(1));
                    row_next = i_c;
                end
            end
            else
            begin
                load_idx_next = load_last ? '0 : li_inc[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            load_idx_reg <= load_idx_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end
endmodule

/* hdl/irot90_back.sv */
module irot90_back #(
    parameter int MAX_SIDE   = 256,
    parameter int MAX_PIXELS = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  irot90_pkg::item_tag_t       tag,
    input  irot90_pkg::pixel_t          pix,
    input  logic [((($clog2(MAX_SIDE)+$clog2(MAX_SIDE+1)) > $clog2(MAX_PIXELS)) ?
                   ($clog2(MAX_SIDE)+$clog2(MAX_SIDE+1)) : $clog2(MAX_PIXELS))-1:0] base,
    input  logic [$clog2(MAX_SIDE)-1:0] offset,
    output logic                        pop,
    irot90_out_if.source                pix_out
);
    import irot90_pkg::*;

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int PROD_W = CW + SIDE_W;
    localparam int BASE_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
    localparam int SUM_W  = BASE_W + 1;

    logic [SUM_W-1:0] addr_sum;
    logic             in_range;
    logic             ram_we, ram_re;
    pixel_t           ram_rdata;

    logic      s1_valid_reg, s1_valid_next;
    item_tag_t s1_tag_reg;
    logic      s1_hit_reg;
    logic      s1_adv;

    logic      out_valid_reg, out_valid_next;
    pixel_t    out_pix_reg;
    logic      out_pv_reg;
    logic      out_last_reg;

    assign addr_sum = SUM_W'(base) + SUM_W'(offset);
    assign in_range = (64'(addr_sum) < 64'(MAX_PIXELS));

    // the ram stage moves on when the output register is free or being drained
    assign s1_adv = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign pop    = q_valid && (!s1_valid_reg || s1_adv);
    assign ram_we = pop && !tag.is_read;
    assign ram_re = pop && tag.is_read && in_range;

    irot90_ram #(
        .WIDTH($bits(pixel_t)),
        .DEPTH(MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (addr_sum[ADDR_W-1:0]),
        .wdata (pix),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_tag_reg <= tag;
            s1_hit_reg <= tag.is_read && in_range;
        end
        if (s1_adv)
        begin
            out_pix_reg  <= s1_hit_reg ? ram_rdata : '0;
            out_pv_reg   <= s1_tag_reg.is_read;
            out_last_reg <= s1_tag_reg.last;
        end
    end

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.red_out     = out_pix_reg.red;
    assign pix_out.green_out   = out_pix_reg.green;
    assign pix_out.blue_out    = out_pix_reg.blue;
    assign pix_out.pixel_valid = out_pv_reg;
    assign pix_out.frame_last  = out_last_reg;
endmodule

/* hdl/image_rotate_90.sv */
// 90 degree frame rotation engine
// pix_in carries one word per item: command 0 loads the next source pixel in
// raster order, command 1 reads the next pixel of the rotated frame.
// pix_out returns exactly one word per item, in order: the rotated pixel with
// pixel_valid set for a read, zero colour for a load; frame_last marks the
// final pixel of a loaded or rotated frame.
// cfg_we/cfg_index/cfg_data write width, height and direction; write them only
// while no item is in flight. sizes are clamped to 1..MAX_SIDE on write.
// throughput is one item per cycle while pix_out is ready: the counters and address
// product are formed on accept, a two-word queue decouples them from the store port.
// from accept the result passes the queue word, written at the accepting edge, then
// the frame store read and the output register before it is shown.
// when pix_out stalls the output register and the store stage hold, the queue
// fills, and pix_in.ready drops once both queue words are taken.
// reset clears the counters and sets a 1x1 clockwise frame; the frame store
// is not cleared and must be loaded before it is read.
`include "image_rotate_90_macros.svh"

module image_rotate_90 #(
    parameter int MAX_SIDE   = 256,
    parameter int MAX_PIXELS = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    irot90_in_if.sink                           pix_in,
    irot90_out_if.source                        pix_out,
    input  logic                                cfg_we,
    input  logic [irot90_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irot90_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import irot90_pkg::*;

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int PROD_W = CW + SIDE_W;
    localparam int BASE_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
    localparam int TOT_W  = 2 * SIDE_W;
    localparam int QW     = $bits(item_tag_t) + $bits(pixel_t) + BASE_W + CW;

    logic [SIDE_W-1:0] w_reg, w_next;
    logic [SIDE_W-1:0] h_reg, h_next;
    logic              dir_reg, dir_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SIDE_W-1:0] side_wr;

    logic              f_push;
    item_tag_t         f_tag;
    pixel_t            f_pix;
    logic [BASE_W-1:0] f_base;
    logic [CW-1:0]     f_off;

    logic              q_full, q_valid, q_pop;
    logic [QW-1:0]     q_wdata, q_rdata;

    item_tag_t         b_tag;
    pixel_t            b_pix;
    logic [BASE_W-1:0] b_base;
    logic [CW-1:0]     b_off;

    logic              sides_legal;
    logic              count_legal;
    logic              load_word;
    logic              colour_blank;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0)
        begin
            clamp_side = SIDE_W'(1);
        end
        else if (v32 > 32'(MAX_SIDE))
        begin
            clamp_side = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            clamp_side = SIDE_W'(v32);
        end
    endfunction

    function automatic logic [CNT_W-1:0] count_of(input logic [SIDE_W-1:0] a,
                                                 input logic [SIDE_W-1:0] b);
        logic [TOT_W-1:0] p;
        p = TOT_W'(a) * TOT_W'(b);
        if (64'(p) > 64'(MAX_PIXELS))
        begin
            count_of = CNT_W'(MAX_PIXELS);
        end
        else
        begin
            count_of = CNT_W'(p);
        end
    endfunction

    assign side_wr = clamp_side(cfg_data);

    // frame size product is settled at write time
    always_comb
    begin
        w_next     = w_reg;
        h_next     = h_reg;
        dir_next   = dir_reg;
        count_next = count_reg;
        if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    w_next     = side_wr;
                    count_next = count_of(side_wr, h_reg);
                end
                REG_IMAGE_HEIGHT:
                begin
                    h_next     = side_wr;
                    count_next = count_of(w_reg, side_wr);
                end
                REG_ROTATE_DIR:
                begin
                    dir_next = cfg_data[0];
                end
                default:
                begin
                    dir_next = dir_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= SIDE_W'(1);
            h_reg     <= SIDE_W'(1);
            dir_reg   <= DIR_CW;
            count_reg <= CNT_W'(1);
        end
        else
        begin
            w_reg     <= w_next;
            h_reg     <= h_next;
            dir_reg   <= dir_next;
            count_reg <= count_next;
        end
    end

    irot90_front #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_in      (pix_in),
        .side_w      (w_reg),
        .side_h      (h_reg),
        .dir         (dir_reg),
        .frame_count (count_reg),
        .q_full      (q_full),
        .push        (f_push),
        .tag         (f_tag),
        .pix         (f_pix),
        .base        (f_base),
        .offset      (f_off)
    );

    assign q_wdata = {f_tag, f_pix, f_base, f_off};

    irot90_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    assign {b_tag, b_pix, b_base, b_off} = q_rdata;

    irot90_back #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .tag     (b_tag),
        .pix     (b_pix),
        .base    (b_base),
        .offset  (b_off),
        .pop     (q_pop),
        .pix_out (pix_out)
    );

    assign sides_legal  = (w_reg != '0) && (h_reg != '0) &&
                          (32'(w_reg) <= 32'(MAX_SIDE)) && (32'(h_reg) <= 32'(MAX_SIDE));
    assign count_legal  = (count_reg != '0) && (32'(count_reg) <= 32'(MAX_PIXELS));
    assign load_word    = pix_out.valid && !pix_out.pixel_valid;
    assign colour_blank = (pix_out.red_out == 8'd0) && (pix_out.green_out == 8'd0) &&
                          (pix_out.blue_out == 8'd0);

    `IROT_CHECK_NEXT(a_side_clamped, cfg_we, sides_legal, "frame side out of range after a write")
    `IROT_CHECK(a_count_bounded, q_valid, count_legal, "frame pixel count out of bounds")
    `IROT_CHECK(a_load_word_blank, load_word, colour_blank, "load result carries colour")
    `IROT_CHECK(a_pop_has_word, q_pop, q_valid, "store stage took a word from an empty queue")
endmodule

/* bench/image_rotate_90_tb.sv */
module image_rotate_90_tb;
    import irot90_pkg::*;

    localparam int MAX_SIDE   = 256;
    localparam int MAX_PIXELS = 65536;
    localparam int RAND_ITEMS = 340;

    typedef struct packed {
        pixel_t pix;
        logic   pixel_valid;
        logic   last;
    } rot_word_t;

    // predicts the rotated stream and holds the words still owed by the block
    class rotated_frame_board;
        pixel_t                store_mem [MAX_PIXELS];
        bit                    written   [MAX_PIXELS];
        int unsigned           load_ptr;
        int unsigned           row_ptr;
        int unsigned           col_ptr;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        logic                  dir_reg;
        rot_word_t             owed_words [$];
        int                    errors;

        function new();
            load_ptr   = 0;
            row_ptr    = 0;
            col_ptr    = 0;
            width_reg  = 1;
            height_reg = 1;
            dir_reg    = DIR_CW;
            errors     = 0;
        endfunction

        function int unsigned side(logic [CFG_DATA_W-1:0] v);
            if (v == 0)
            begin
                return 1;
            end
            if (v > MAX_SIDE)
            begin
                return MAX_SIDE;
            end
            return v;
        endfunction

        function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = data;
                REG_IMAGE_HEIGHT: height_reg = data;
                REG_ROTATE_DIR:   dir_reg    = data[0];
                default: ;
            endcase
        endfunction

        // source address of the next rotated pixel, counters restarted if outside the frame
        function int unsigned rotated_addr(output int unsigned row, output int unsigned col);
            int unsigned w;
            int unsigned h;
            w   = side(width_reg);
            h   = side(height_reg);
            row = (row_ptr >= w) ? 0 : row_ptr;
            col = (col_ptr >= h) ? 0 : col_ptr;
            if (dir_reg == DIR_CW)
            begin
                return (h - 1 - col) * w + row;
            end
            return col * w + (w - 1 - row);
        endfunction

        function bit read_ok();
            int unsigned r;
            int unsigned c;
            int unsigned a;
            a = rotated_addr(r, c);
            return (a >= MAX_PIXELS) || written[a];
        endfunction

        function void take_input(logic cmd, pixel_t p);
            rot_word_t   want;
            int unsigned w;
            int unsigned h;
            int unsigned count;
            int unsigned r;
            int unsigned c;
            int unsigned a;
            w    = side(width_reg);
            h    = side(height_reg);
            want = '0;
            if (cmd == CMD_LOAD)
            begin
                count = (w * h < MAX_PIXELS) ? w * h : MAX_PIXELS;
                if (load_ptr >= count)
                begin
                    load_ptr = 0;
                end
                store_mem[load_ptr] = p;
                written[load_ptr]   = 1'b1;
                if (load_ptr + 1 >= count)
                begin
                    want.last = 1'b1;
                    load_ptr  = 0;
                end
                else
                begin
                    load_ptr++;
                end
            end
            else
            begin
                a = rotated_addr(r, c);
                if (a < MAX_PIXELS)
                begin
                    want.pix = store_mem[a];
                end
                want.pixel_valid = 1'b1;
                want.last        = (r == w - 1) && (c == h - 1);
                if (c + 1 >= h)
                begin
                    col_ptr = 0;
                    row_ptr = (r + 1 >= w) ? 0 : r + 1;
                end
                else
                begin
                    row_ptr = r;
                    col_ptr = c + 1;
                end
            end
            owed_words.push_back(want);
        endfunction

        function void match_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rot_word_t got);
            rot_word_t want;
            if (owed_words.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = owed_words.pop_front();
            match_field("red_out",     want.pix.red,     got.pix.red);
            match_field("green_out",   want.pix.green,   got.pix.green);
            match_field("blue_out",    want.pix.blue,    got.pix.blue);
            match_field("pixel_valid", want.pixel_valid, got.pixel_valid);
            match_field("frame_last",  want.last,        got.last);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit          quiet_tail;
    bit          gaps_on;
    int unsigned items_sent;

    pixel_t corner_px [6] = '{24'h000000, 24'hFFFFFF, 24'hAA55AA,
                              24'h55AA55, 24'h0F0F0F, 24'hF0F0F0};

    rotated_frame_board board = new();

    irot90_in_if  pix_in ();
    irot90_out_if pix_out ();

    image_rotate_90 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.red   = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        p.blue  = 8'($urandom_range(0, 255));
        return p;
    endfunction

    // a read is turned into a load when it would reach an entry never loaded
    task automatic send_item(input bit want_read, input pixel_t p);
        logic cmd;
        cmd = (want_read && board.read_ok()) ? CMD_READ : CMD_LOAD;
        pix_in.valid    <= 1'b1;
        pix_in.command  <= cmd;
        pix_in.red_in   <= p.red;
        pix_in.green_in <= p.green;
        pix_in.blue_in  <= p.blue;
        do
            @(posedge clk);
        while (!pix_in.ready);
        board.take_input(cmd, p);
        items_sent++;
        @(negedge clk);
        if (gaps_on && !quiet_tail && $urandom_range(0, 5) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (board.owed_words.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] dir_data);
        drain();
        write_cfg(REG_IMAGE_WIDTH, w);
        write_cfg(REG_IMAGE_HEIGHT, h);
        write_cfg(REG_ROTATE_DIR, dir_data);
    endtask

    task automatic run_phase(input bit big);
        int unsigned w;
        int unsigned h;
        int unsigned frame_px;
        if (big)
        begin
            w = $urandom_range(0, 1) ? MAX_SIDE : $urandom_range(MAX_SIDE, 511);
            h = $urandom_range(0, 2);
            if ($urandom_range(0, 1))
            begin
                {w, h} = {h, w};
            end
        end
        else
        begin
            w = $urandom_range(0, 5);
            h = $urandom_range(0, 5);
        end
        // direction sits in bit 0, the upper bits are don't-care
        set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h),
                  CFG_DATA_W'(($urandom_range(0, 255) << 1) | $urandom_range(0, 1)));
        gaps_on  = ($urandom_range(0, 2) != 0);
        frame_px = board.side(CFG_DATA_W'(w)) * board.side(CFG_DATA_W'(h));
        if (big)
        begin
            repeat (60) send_item(1'($urandom_range(0, 1)), rand_pixel());
        end
        else if ($urandom_range(0, 4) != 0)
        begin
            repeat (frame_px) send_item(1'b0, rand_pixel());
            if ($urandom_range(0, 1))
            begin
                drain();
            end
            repeat ($urandom_range(1, 2) * frame_px)
            begin
                send_item($urandom_range(0, 9) != 0, rand_pixel());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 2 * frame_px + 2))
            begin
                send_item(1'($urandom_range(0, 1)), rand_pixel());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            board.check_result({pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                                pix_out.pixel_valid, pix_out.frame_last});
        end
    end

    // receiver stalls in bursts, never in the tail
    initial
    begin
        pix_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            pix_out.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    end

    initial
    begin
        int unsigned rand_start;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_IMAGE_WIDTH;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.command  = CMD_LOAD;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        quiet_tail      = 1'b0;
        gaps_on         = 1'b0;
        items_sent      = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 1x1 frame straight out of reset: every word is the last one
        send_item(1'b0, 24'hFFFFFF);
        send_item(1'b1, rand_pixel());

        set_frame(3, 2, DIR_CW);
        foreach (corner_px[k])
        begin
            send_item(1'b0, corner_px[k]);
        end
        repeat (6) send_item(1'b1, rand_pixel());
        drain();
        write_cfg(REG_ROTATE_DIR, {8'hFF, DIR_CCW});
        repeat (6) send_item(1'b1, rand_pixel());

        // zero and oversize sides clamp to 1 and MAX_SIDE; read back a partly loaded frame
        set_frame(0, 511, DIR_CCW);
        repeat (3) send_item(1'b0, rand_pixel());
        repeat (3) send_item(1'b1, rand_pixel());

        rand_start = items_sent;
        while (items_sent < rand_start + RAND_ITEMS)
        begin
            run_phase($urandom_range(0, 7) == 0);
        end

        quiet_tail = 1'b1;
        gaps_on    = 1'b0;
        set_frame(4, 3, DIR_CW);
        repeat (12) send_item(1'b0, rand_pixel());
        repeat (12) send_item(1'b1, rand_pixel());

        drain();
        repeat (10) @(negedge clk);
        if (board.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
